/* hw/rtl/pdr_pkg.sv */
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared field widths, operation and status codes, configuration register
// indexes and the transition entry layout of the DFA runner.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int OP_W       = 2;
  localparam int STATE_W    = 4;
  localparam int COL_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int MASK_W     = 16;
  localparam int SYMCNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SYMBOL = 2'd0,
    OP_LOAD_TRANS  = 2'd1,
    OP_START       = 2'd2,
    OP_FEED        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED   = 3'd0,
    ST_STARTED  = 3'd1,
    ST_MOVED    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_NO_TRANS = 3'd4,
    ST_ACCEPTED = 3'd5,
    ST_ENDED    = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 2'd2;

  // Character that closes a word without acceptance.
  localparam logic [CHAR_W-1:0] WORD_END_CHAR = 8'h20;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next;
  } trans_entry_t;

endpackage

/* hw/rtl/pdr_if.sv */
// ----------------------------------------------------------------------------
// pdr_in_if / pdr_out_if
// Valid/ready channels of the DFA runner: request items in, result items out.
// ----------------------------------------------------------------------------
interface pdr_in_if import pdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [STATE_W-1:0] slot;
  logic [COL_W-1:0]   column;
  logic [CHAR_W-1:0]  symbol_char;
  logic [STATE_W-1:0] next_state;
  logic               entry_valid;

  modport source (
    output valid, operation, slot, column, symbol_char, next_state, entry_valid,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, column, symbol_char, next_state, entry_valid,
    output ready
  );
endinterface

interface pdr_out_if import pdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STATE_W-1:0]  current_state;

  modport source (
    output valid, status, current_state,
    input  ready
  );
  modport sink (
    input  valid, status, current_state,
    output ready
  );
endinterface

/* hw/rtl/pdr_ram.sv */
// ----------------------------------------------------------------------------
// pdr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pdr_sym_match.sv */
// ----------------------------------------------------------------------------
// pdr_sym_match
// Alphabet register row: one character per slot, compared in parallel with
// the fed character; the lowest matching slot in use wins.
// ----------------------------------------------------------------------------
module pdr_sym_match import pdr_pkg::*; #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(MAX_SYMBOLS)-1:0] wr_slot,
  input  logic [CHAR_W-1:0]              wr_char,
  input  logic [CHAR_W-1:0]              lookup_char,
  input  logic [SYMCNT_W-1:0]            symbol_count,
  output logic                           hit,
  output logic [$clog2(MAX_SYMBOLS)-1:0] hit_idx
);

  localparam int SYM_W = $clog2(MAX_SYMBOLS);

  logic [CHAR_W-1:0]      sym_r [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_r[wr_slot] <= wr_char;
    end
  end

  // slots at or above the count are out of play; a count above the table
  // size simply covers every slot
  always_comb begin
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      match[k] = (k < int'(symbol_count)) && (sym_r[k] == lookup_char);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit     = 1'b1;
        hit_idx = SYM_W'(k);
      end
    end
  end

endmodule

/* hw/rtl/programmable_dfa_runner.sv */
// ----------------------------------------------------------------------------
// programmable_dfa_runner
// Table-driven deterministic finite automaton with a loadable alphabet and
// transition table.
// ----------------------------------------------------------------------------
// A request passes an accept step and a resolve step: the accepting edge
// does the alphabet match and launches the transition-table read, the
// resolve step loads the result register from the read data, and the block
// takes its next request only once back in idle, as the RAM read is
// registered. The result register decouples the output: a request is still
// accepted while the previous result waits, and it then waits in the resolve
// step until the result register frees. After reset the transition RAM is
// swept to invalid, one entry per cycle, over all MAX_STATES * MAX_SYMBOLS
// entries (256 at the defaults); in_req.ready stays low during the sweep,
// while configuration writes are taken at any time. The alphabet is undefined
// until loaded. Configuration may only change while no request is in flight.
// ----------------------------------------------------------------------------
module programmable_dfa_runner import pdr_pkg::*; #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pdr_in_if.sink                in_req,
  pdr_out_if.source             out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH   = MAX_STATES * MAX_SYMBOLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SYM_W   = $clog2(MAX_SYMBOLS);
  localparam int ENTRY_W = $bits(trans_entry_t);

  typedef enum logic [2:0] {
    S_CLEAR   = 3'b001,
    S_IDLE    = 3'b010,
    S_RESOLVE = 3'b100
  } fsm_t;

  fsm_t                fsm_r, fsm_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;

  // configuration registers
  logic [STATE_W-1:0]  initial_state_r;
  logic [MASK_W-1:0]   final_mask_r;
  logic [SYMCNT_W-1:0] symbol_count_r;

  // automaton state
  logic [STATE_W-1:0]  present_r, present_nxt;
  logic                running_r, running_nxt;

  // request in flight
  status_t             pend_status_r, pend_status_nxt;
  logic                lookup_r, lookup_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [STATE_W-1:0]  out_state_r, out_state_nxt;

  logic                in_acc;
  op_t                 op;
  logic                slot_ok_sym;
  logic                trans_ok;
  logic                init_ok;
  logic                sym_wr;
  logic                sym_hit;
  logic [SYM_W-1:0]    sym_idx;
  logic [ADDR_W-1:0]   ld_addr;
  logic [ADDR_W-1:0]   feed_addr;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  trans_entry_t        entry;
  logic                out_load;

  // --------------------------------------------------------------------------
  // Handshake and request decode
  // --------------------------------------------------------------------------
  assign in_req.ready = (fsm_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign op           = op_t'(in_req.operation);

  // range checks: loads and starts that fall outside the tables are ignored
  assign slot_ok_sym = int'(in_req.slot) < MAX_SYMBOLS;
  assign trans_ok    = (int'(in_req.slot) < MAX_STATES) &&
                       (int'(in_req.column) < MAX_SYMBOLS) &&
                       (int'(in_req.next_state) < MAX_STATES);
  assign init_ok     = int'(initial_state_r) < MAX_STATES;

  assign sym_wr = in_acc && (op == OP_LOAD_SYMBOL) && slot_ok_sym;

  // --------------------------------------------------------------------------
  // Alphabet match
  // --------------------------------------------------------------------------
  pdr_sym_match #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_sym_match (
    .clk          (clk),
    .wr_en        (sym_wr),
    .wr_slot      (SYM_W'(in_req.slot)),
    .wr_char      (in_req.symbol_char),
    .lookup_char  (in_req.symbol_char),
    .symbol_count (symbol_count_r),
    .hit          (sym_hit),
    .hit_idx      (sym_idx)
  );

  // --------------------------------------------------------------------------
  // Transition table: row per state, column per alphabet slot
  // --------------------------------------------------------------------------
  assign ld_addr   = ADDR_W'(in_req.slot) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(in_req.column);
  assign feed_addr = ADDR_W'(present_r) * ADDR_W'(MAX_SYMBOLS) + ADDR_W'(sym_idx);

  // the clearing sweep owns the write port until it finishes; loads can
  // only arrive afterwards since ready is low meanwhile
  assign ram_we    = (fsm_r == S_CLEAR) || (in_acc && (op == OP_LOAD_TRANS) && trans_ok);
  assign ram_waddr = (fsm_r == S_CLEAR) ? clr_addr_r : ld_addr;
  assign ram_wdata = (fsm_r == S_CLEAR) ? '0 : {in_req.entry_valid, in_req.next_state};
  assign ram_re    = in_acc && (op == OP_FEED);

  pdr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (feed_addr),
    .rdata (ram_rdata)
  );

  assign entry = trans_entry_t'(ram_rdata);

  // load the result register when it is empty or being drained this cycle
  assign out_load = (fsm_r == S_RESOLVE) && (!out_valid_r || out_rsp.ready);

  // --------------------------------------------------------------------------
  // Control: clear sweep, accept, resolve
  // --------------------------------------------------------------------------
  always_comb begin
    fsm_nxt         = fsm_r;
    clr_addr_nxt    = clr_addr_r;
    present_nxt     = present_r;
    running_nxt     = running_r;
    pend_status_nxt = pend_status_r;
    lookup_nxt      = lookup_r;
    out_status_nxt  = out_status_r;
    out_state_nxt   = out_state_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;

    unique case (fsm_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          fsm_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          fsm_nxt         = S_RESOLVE;
          lookup_nxt      = 1'b0;
          pend_status_nxt = ST_IGNORED;
          case (op)
            OP_LOAD_SYMBOL: begin
              if (slot_ok_sym) begin
                pend_status_nxt = ST_LOADED;
              end
            end
            OP_LOAD_TRANS: begin
              if (trans_ok) begin
                pend_status_nxt = ST_LOADED;
              end
            end
            OP_START: begin
              if (init_ok) begin
                present_nxt = initial_state_r;
                // a final initial state accepts the empty word at once
                if (final_mask_r[initial_state_r]) begin
                  running_nxt     = 1'b0;
                  pend_status_nxt = ST_ACCEPTED;
                end else begin
                  running_nxt     = 1'b1;
                  pend_status_nxt = ST_STARTED;
                end
              end
            end
            OP_FEED: begin
              if (running_r) begin
                if (in_req.symbol_char == WORD_END_CHAR) begin
                  running_nxt     = 1'b0;
                  pend_status_nxt = ST_ENDED;
                end else if (!sym_hit) begin
                  pend_status_nxt = ST_UNKNOWN;
                end else begin
                  // outcome depends on the table entry read this edge
                  lookup_nxt = 1'b1;
                end
              end
            end
            default: begin
              pend_status_nxt = ST_IGNORED;
            end
          endcase
        end
      end

      S_RESOLVE: begin
        if (out_load) begin
          fsm_nxt        = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          if (lookup_r) begin
            if (!entry.valid) begin
              out_status_nxt = ST_NO_TRANS;
            end else begin
              present_nxt = entry.next;
              if (final_mask_r[entry.next]) begin
                running_nxt    = 1'b0;
                out_status_nxt = ST_ACCEPTED;
              end else begin
                out_status_nxt = ST_MOVED;
              end
            end
          end
          out_state_nxt = present_nxt;
        end
      end

      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= S_CLEAR;
      clr_addr_r    <= '0;
      present_r     <= '0;
      running_r     <= 1'b0;
      pend_status_r <= ST_IGNORED;
      lookup_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      fsm_r         <= fsm_nxt;
      clr_addr_r    <= clr_addr_nxt;
      present_r     <= present_nxt;
      running_r     <= running_nxt;
      pend_status_r <= pend_status_nxt;
      lookup_r      <= lookup_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_state_r  <= out_state_nxt;
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_state_r <= '0;
      final_mask_r    <= '0;
      symbol_count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_STATE: initial_state_r <= cfg_wdata[STATE_W-1:0];
        CFG_FINAL_MASK:    final_mask_r    <= cfg_wdata[MASK_W-1:0];
        CFG_SYMBOL_COUNT:  symbol_count_r  <= cfg_wdata[SYMCNT_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.current_state = out_state_r;

endmodule

/* hw/rtl/pdr_checker.sv */
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks of the DFA runner, bound to the top level.
// ----------------------------------------------------------------------------
module pdr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [3:0] out_current_state
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a request meeting a free result slot yields its result without stalling in the resolve step
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (!out_valid || out_ready)) |-> ##2 out_valid)
    else $error("result missing two cycles after request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_current_state)))
    else $error("stalled result changed");

  // reset empties the result register and starts the table sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("block active right after reset");

endmodule

bind programmable_dfa_runner pdr_checker u_pdr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_current_state (out_rsp.current_state)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the programmable DFA runner. A queue of requests
// feeds a valid/ready driver. Each accepted request steps a behavioral copy
// of the automaton, which queues the expected status and state. A monitor
// compares every result against that queue. Random idling on both channels
// and several register settings exercise loads, words and rejected
// characters.
// ----------------------------------------------------------------------------
module tb_top;
  import pdr_pkg::*;

  localparam int NUM_STATES     = 16;
  localparam int NUM_SYMBOLS    = 16;
  // Quiet cycles allowed before giving up; covers the table sweep
  // after reset plus long random stalls on both sides.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last result.
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] slot;
    logic [COL_W-1:0]   column;
    logic [CHAR_W-1:0]  ch;
    logic [STATE_W-1:0] nxt;
    logic               valid;
  } dfa_req_t;

  typedef struct packed {
    status_t            status;
    logic [STATE_W-1:0] state;
  } dfa_rsp_t;

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block under test
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pdr_in_if  in_ch ();
  pdr_out_if out_ch ();

  logic                  req_valid = 1'b0;
  dfa_req_t              req_item  = '0;
  logic                  rsp_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Every block input is tied to a testbench variable that starts known.
  assign in_ch.valid       = req_valid;
  assign in_ch.operation   = req_item.op;
  assign in_ch.slot        = req_item.slot;
  assign in_ch.column      = req_item.column;
  assign in_ch.symbol_char = req_item.ch;
  assign in_ch.next_state  = req_item.nxt;
  assign in_ch.entry_valid = req_item.valid;
  assign out_ch.ready      = rsp_ready;

  programmable_dfa_runner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_rsp   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Behavioral automaton: register copies, tables and the running word
  // --------------------------------------------------------------------------
  logic [STATE_W-1:0]  start_state_reg = '0;
  logic [MASK_W-1:0]   accept_mask     = '0;
  logic [SYMCNT_W-1:0] alpha_count_reg = '0;

  logic [CHAR_W-1:0]   alpha_tab [NUM_SYMBOLS];
  trans_entry_t        trans_tab [NUM_STATES*NUM_SYMBOLS];
  logic [STATE_W-1:0]  dfa_state = '0;
  logic                word_open = 1'b0;

  initial begin
    foreach (alpha_tab[k]) alpha_tab[k] = '0;
    foreach (trans_tab[k]) trans_tab[k] = '0;
  end

  // Step the automaton with one accepted request and return its result.
  function automatic dfa_rsp_t dfa_next(input dfa_req_t r);
    dfa_rsp_t     rsp;
    int           used;
    int           hit;
    trans_entry_t e;
    rsp.status = ST_IGNORED;
    case (r.op)
      OP_LOAD_SYMBOL: begin
        alpha_tab[r.slot] = r.ch;
        rsp.status = ST_LOADED;
      end
      OP_LOAD_TRANS: begin
        e.valid = r.valid;
        e.next  = r.nxt;
        trans_tab[{r.slot, r.column}] = e;
        rsp.status = ST_LOADED;
      end
      OP_START: begin
        if (start_state_reg < NUM_STATES) begin
          dfa_state = start_state_reg;
          // An accepting start state closes the word on the spot.
          word_open = !accept_mask[dfa_state];
          rsp.status = accept_mask[dfa_state] ? ST_ACCEPTED : ST_STARTED;
        end
      end
      default: begin
        if (word_open) begin
          if (r.ch == WORD_END_CHAR) begin
            word_open = 1'b0;
            rsp.status = ST_ENDED;
          end else begin
            // Counts above the table size clamp; lowest matching slot wins.
            used = (alpha_count_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : alpha_count_reg;
            hit  = -1;
            for (int k = 0; k < used; k++)
              if (hit < 0 && alpha_tab[k] == r.ch) hit = k;
            if (hit < 0) begin
              rsp.status = ST_UNKNOWN;
            end else begin
              e = trans_tab[{dfa_state, hit[COL_W-1:0]}];
              if (!e.valid) begin
                rsp.status = ST_NO_TRANS;
              end else begin
                dfa_state = e.next;
                word_open = !accept_mask[dfa_state];
                rsp.status = accept_mask[dfa_state] ? ST_ACCEPTED : ST_MOVED;
              end
            end
          end
        end
      end
    endcase
    rsp.state = dfa_state;
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver and result monitor
  // --------------------------------------------------------------------------
  dfa_req_t    pending_reqs [$];
  dfa_rsp_t    expected_rsp [$];
  int unsigned send_idle = 21;
  int unsigned recv_idle = 45;
  int unsigned errors    = 0;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // Hold a request until it is taken; predict it on the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && in_ch.ready) expected_rsp.push_back(dfa_next(req_item));
      if (!req_valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          req_item  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each taken result with the oldest prediction, then redraw ready.
  always @(posedge clk) begin : rsp_monitor
    dfa_rsp_t want;
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_error($sformatf("result status %0d state %0d with no request pending",
                                 out_ch.status, out_ch.current_state));
        end else begin
          want = expected_rsp.pop_front();
          if (out_ch.status !== want.status)
            report_error($sformatf("status got %0d expected %0d (%s)",
                                   out_ch.status, want.status, want.status.name()));
          if (out_ch.current_state !== want.state)
            report_error($sformatf("current_state got %0d expected %0d",
                                   out_ch.current_state, want.state));
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Stop a hung run: count cycles in which neither channel moves.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((req_valid && in_ch.ready) || (out_ch.valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0] gen_alpha [NUM_SYMBOLS];  // alphabet as queued so far
  int                alpha_used = 0;           // slots in use for matching

  initial foreach (gen_alpha[k]) gen_alpha[k] = '0;

  task automatic push_req(input op_t op, input logic [STATE_W-1:0] slot,
                          input logic [COL_W-1:0] column, input logic [CHAR_W-1:0] ch,
                          input logic [STATE_W-1:0] nxt, input logic valid);
    dfa_req_t r;
    r = '{op: op, slot: slot, column: column, ch: ch, nxt: nxt, valid: valid};
    if (op == OP_LOAD_SYMBOL) gen_alpha[slot] = ch;
    pending_reqs.push_back(r);
  endtask

  // Fields that an operation ignores get random values.
  task automatic load_sym(input logic [STATE_W-1:0] slot, input logic [CHAR_W-1:0] ch);
    push_req(OP_LOAD_SYMBOL, slot, $urandom_range(15), ch, $urandom_range(15),
             $urandom_range(1));
  endtask

  task automatic load_trans(input logic [STATE_W-1:0] src, input logic [COL_W-1:0] col,
                            input logic [STATE_W-1:0] dst, input logic valid);
    push_req(OP_LOAD_TRANS, src, col, $urandom_range(255), dst, valid);
  endtask

  task automatic start_word();
    push_req(OP_START, $urandom_range(15), $urandom_range(15), $urandom_range(255),
             $urandom_range(15), $urandom_range(1));
  endtask

  task automatic feed(input logic [CHAR_W-1:0] ch);
    push_req(OP_FEED, $urandom_range(15), $urandom_range(15), ch, $urandom_range(15),
             $urandom_range(1));
  endtask

  function automatic logic [CHAR_W-1:0] known_char();
    if (alpha_used == 0) return $urandom_range(255);
    return gen_alpha[$urandom_range(alpha_used - 1)];
  endfunction

  // Mostly target columns that the current alphabet can reach.
  function automatic logic [COL_W-1:0] pick_column();
    if (alpha_used == 0 || $urandom_range(9) == 0) return $urandom_range(15);
    return $urandom_range(alpha_used - 1);
  endfunction

  // Wait until no request is queued, offered or awaiting its result. Look on
  // the falling edge, once the driver and monitor of the rising edge are done.
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0);
  endtask

  // Write one register; the bench copy follows at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_INITIAL_STATE: start_state_reg = data[STATE_W-1:0];
      CFG_FINAL_MASK:    accept_mask     = data[MASK_W-1:0];
      CFG_SYMBOL_COUNT: begin
        alpha_count_reg = data[SYMCNT_W-1:0];
        alpha_used = (alpha_count_reg > NUM_SYMBOLS) ? NUM_SYMBOLS : alpha_count_reg;
      end
      default: ;
    endcase
  endtask

  // One random phase: idle, set the registers, reload the whole alphabet,
  // then mostly well-formed words over random tables with noise mixed in.
  task automatic run_phase(input int init, input int mask, input int count,
                           input int n_items);
    int n_left;
    int pick;
    int sel;
    int len;
    drain();
    write_reg(CFG_INITIAL_STATE, init);
    write_reg(CFG_FINAL_MASK, mask);
    write_reg(CFG_SYMBOL_COUNT, count);
    // Refill every slot so no feed ever scans an unwritten one; seed a few
    // duplicates so the lowest slot has to win.
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (k > 0 && $urandom_range(9) == 0) load_sym(k, gen_alpha[$urandom_range(k - 1)]);
      else load_sym(k, $urandom_range(255));
    end
    n_left = n_items;
    while (n_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        start_word();
        n_left--;
        len = $urandom_range(1, 8);
        repeat (len) begin
          sel = $urandom_range(99);
          if (sel < 80) feed(known_char());
          else if (sel < 88) feed(WORD_END_CHAR);
          else feed($urandom_range(255));
          n_left--;
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 6)) begin
          load_trans($urandom_range(15), pick_column(), $urandom_range(15),
                     $urandom_range(99) < 85);
          n_left--;
        end
      end else if (pick < 72) begin
        load_sym($urandom_range(15), $urandom_range(255));
        n_left--;
      end else if (pick < 85) begin
        push_req(op_t'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                 $urandom_range(255), $urandom_range(15), $urandom_range(1));
        n_left--;
      end else begin
        // Stray character: often lands after the word has already closed.
        feed(known_char());
        n_left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty alphabet, no accepting state.
    feed(8'h61);                    // no word open: ignored
    start_word();                   // start in state zero
    feed(8'h78);                    // nothing in use to match: unknown
    feed(WORD_END_CHAR);            // space closes the word unaccepted
    load_sym(0, 8'h61);
    load_sym(1, 8'h00);             // lowest character
    load_sym(2, 8'hFF);             // highest character
    load_sym(3, 8'h61);             // duplicate of slot zero
    load_sym(15, 8'hFF);            // last slot
    drain();

    // Chain 0 -> 1 -> 2 -> 3 with state 3 accepting, four slots in use.
    write_reg(CFG_INITIAL_STATE, 0);
    write_reg(CFG_FINAL_MASK, 16'h0008);
    write_reg(CFG_SYMBOL_COUNT, 4);
    load_trans(0, 0, 1, 1'b1);
    load_trans(1, 1, 2, 1'b1);
    load_trans(2, 2, 3, 1'b1);
    load_trans(15, 15, 15, 1'b0);   // extreme indexes, entry marked invalid
    load_trans(1, 3, 0, 1'b0);
    start_word();
    feed(8'h71);                    // not in the alphabet: state kept
    feed(8'hFF);                    // known, but state 0 has no entry there
    feed(8'h61);                    // slot 0 beats its duplicate: move to 1
    feed(8'h00);                    // move to 2
    feed(8'hFF);                    // reach 3 and accept
    feed(8'h61);                    // word already closed: ignored
    start_word();
    feed(WORD_END_CHAR);

    // Sender idles lightly, receiver stalls often.
    run_phase(0, 16'h8000, 16, 90);
    run_phase(15, 16'h0001, 31, 90);  // count above table size clamps
    // Roles swapped.
    send_idle = 45;
    recv_idle = 21;
    run_phase(5, 16'hFFFF, 7, 90);    // every start accepts at once
    run_phase(3, 16'h0000, 0, 90);    // nothing matches, nothing accepts
    // Full throughput on both sides.
    send_idle = 0;
    recv_idle = 0;
    run_phase($urandom_range(15), $urandom_range(65535) & $urandom_range(65535),
              $urandom_range(1, 16), 90);
    run_phase(9, 16'h0240, 17, 90);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
